>>> src/chained_hash_map_engine_core_defines.svh
// assertion macros shared by the hash map engine rtl
// no dependencies; included by the top level
`ifndef CHAINED_HASH_MAP_ENGINE_CORE_DEFINES_SVH
`define CHAINED_HASH_MAP_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CMH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hash map engine check failed");

// next-cycle implication, disabled while reset is low
`define CMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hash map engine check failed");

`endif

>>> src/cmh_pkg.sv
// shared types and constants for the chained hash map engine
// no dependencies
package cmh_pkg;

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 9;            // entry index plus the empty code
    localparam int ADDR_W   = 8;            // entry / bucket address
    localparam int DVD_W    = 64;           // widened key
    localparam int CNT_W    = 9;
    localparam int MAX_ENTRIES = 256;
    localparam int MAX_BUCKETS = 256;

    localparam logic [IDX_W-1:0] NO_ENTRY     = 9'd256;
    localparam logic [CNT_W-1:0] BUCKET_RESET = 9'd16;
    localparam logic [CNT_W-1:0] BUCKET_MAX   = 9'd256;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_RESIZE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BAD   = 2'd2,
        ST_SPARE = 2'd3
    } t_status;

    // request to the shared modulo unit
    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } t_mod_req;

    // response from the shared modulo unit
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] rem;
    } t_mod_rsp;

endpackage

>>> src/chained_hash_map_engine_core.sv
// top level of the chained hash map engine: sequencer, pools and link valid bits
// depends on cmh_pkg, cmh_ram, cmh_mod and chained_hash_map_engine_core_defines.svh
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------------------
//  command   | start, busy (take: start&~busy) | i_operation i_key i_value i_new_bucket_count
//  result    | o_valid (one-cycle strobe)  | o_found o_read_value o_status o_entry_count
//
// a get or a miss hashes the key in the modulo unit, reads the bucket head, then walks the
// chain comparing keys; a put insert or a remove hit then writes the chain and free list. the modulo unit is 64-step.
// a valid resize clears the scratch heads for the new count, then walks each old bucket
// and rehashes each stored entry (one modulo each); a rejected resize strobes the next cycle.
// busy is high from acceptance through the strobe cycle; results cannot be held off.
// reset is synchronous; a clearing pass empties the reset buckets, with busy high.
`include "chained_hash_map_engine_core_defines.svh"

module chained_hash_map_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_operation,
    input  logic signed [31:0]          i_key,
    input  logic [31:0]                 i_value,
    input  logic [8:0]                  i_new_bucket_count,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [31:0]                 o_read_value,
    output logic [1:0]                  o_status,
    output logic [8:0]                  o_entry_count
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000000000000001,
        S_MOD      = 16'b0000000000000010,
        S_HEAD     = 16'b0000000000000100,
        S_WALK     = 16'b0000000000001000,
        S_CMP      = 16'b0000000000010000,
        S_REM2     = 16'b0000000000100000,
        S_FREE     = 16'b0000000001000000,
        S_RS_HEAD  = 16'b0000000010000000,
        S_RS_HEADW = 16'b0000000100000000,
        S_RS_ENT   = 16'b0000001000000000,
        S_RS_KEY   = 16'b0000010000000000,
        S_RS_MOD   = 16'b0000100000000000,
        S_RS_SCR   = 16'b0001000000000000,
        S_DONE     = 16'b0010000000000000,
        S_INIT     = 16'b0100000000000000,
        S_RS_CLR   = 16'b1000000000000000
    } t_state;

    t_state                          r_state, n_state;
    cmh_pkg::t_op                    r_op, n_op;
    logic [cmh_pkg::KEY_W-1:0]       r_key, n_key;
    logic [cmh_pkg::VAL_W-1:0]       r_val, n_val;
    logic [cmh_pkg::CNT_W-1:0]       r_nb, n_nb;
    logic [cmh_pkg::ADDR_W-1:0]      r_bkt, n_bkt;
    logic [cmh_pkg::IDX_W-1:0]       r_cur, n_cur;
    logic [cmh_pkg::IDX_W-1:0]       r_prev, n_prev;
    logic [cmh_pkg::IDX_W-1:0]       r_bhead, n_bhead;
    logic [cmh_pkg::IDX_W-1:0]       r_next, n_next;
    logic [cmh_pkg::IDX_W-1:0]       r_free, n_free;
    logic [cmh_pkg::CNT_W-1:0]       r_count, n_count;
    logic [cmh_pkg::CNT_W-1:0]       r_nbuck, n_nbuck;
    logic [cmh_pkg::CNT_W-1:0]       r_idx, n_idx;
    logic                            r_bank, n_bank;
    logic                            r_found, n_found;
    logic [cmh_pkg::VAL_W-1:0]       r_rdval, n_rdval;
    cmh_pkg::t_status                r_status, n_status;

    // valid bits for the link pool
    logic [cmh_pkg::MAX_ENTRIES-1:0]      r_lv;
    logic                                 r_lq_v;
    logic [cmh_pkg::ADDR_W-1:0]           r_lq_a;

    // ram ports
    logic                            head_we;
    logic [cmh_pkg::ADDR_W:0]        head_waddr, head_raddr;
    logic [cmh_pkg::IDX_W-1:0]       head_wdata, head_rdata;
    logic                            key_we, val_we, link_we;
    logic [cmh_pkg::ADDR_W-1:0]      ent_waddr, link_waddr, ent_raddr;
    logic [cmh_pkg::KEY_W-1:0]       key_rdata;
    logic [cmh_pkg::VAL_W-1:0]       val_rdata;
    logic [cmh_pkg::IDX_W-1:0]       link_wdata, link_rdata;
    logic [cmh_pkg::IDX_W-1:0]       hd, lnk;

    cmh_pkg::t_mod_req               mod_req;
    cmh_pkg::t_mod_rsp               mod_rsp;

    // head data, and link data with unwritten rows read as the free list
    assign hd  = head_rdata;
    assign lnk = r_lq_v ? link_rdata : ({1'b0, r_lq_a} + cmh_pkg::IDX_W'(1));

    cmh_ram #(.WIDTH(cmh_pkg::IDX_W), .DEPTH(2 * cmh_pkg::MAX_BUCKETS)) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    cmh_ram #(.WIDTH(cmh_pkg::KEY_W), .DEPTH(cmh_pkg::MAX_ENTRIES)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (ent_waddr),
        .i_wdata (r_key),
        .i_raddr (ent_raddr),
        .o_rdata (key_rdata)
    );

    cmh_ram #(.WIDTH(cmh_pkg::VAL_W), .DEPTH(cmh_pkg::MAX_ENTRIES)) u_vals (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (ent_waddr),
        .i_wdata (r_val),
        .i_raddr (ent_raddr),
        .o_rdata (val_rdata)
    );

    cmh_ram #(.WIDTH(cmh_pkg::IDX_W), .DEPTH(cmh_pkg::MAX_ENTRIES)) u_links (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (link_rdata)
    );

    cmh_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_val    = r_val;
        n_nb     = r_nb;
        n_bkt    = r_bkt;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_bhead  = r_bhead;
        n_next   = r_next;
        n_free   = r_free;
        n_count  = r_count;
        n_nbuck  = r_nbuck;
        n_idx    = r_idx;
        n_bank   = r_bank;
        n_found  = r_found;
        n_rdval  = r_rdval;
        n_status = r_status;
        head_we    = 1'b0;
        head_waddr = {r_bank, r_bkt};
        head_wdata = r_cur;
        head_raddr = '0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        link_we    = 1'b0;
        ent_waddr  = r_cur[cmh_pkg::ADDR_W-1:0];
        link_waddr = r_cur[cmh_pkg::ADDR_W-1:0];
        link_wdata = r_free;
        ent_raddr  = r_cur[cmh_pkg::ADDR_W-1:0];
        mod_req.start    = 1'b0;
        mod_req.dividend = {{(cmh_pkg::DVD_W - cmh_pkg::KEY_W){i_key[31]}}, i_key};
        mod_req.divisor  = r_nbuck;

        unique case (r_state)
            S_INIT: begin
                // empty the buckets in use after reset
                head_we    = 1'b1;
                head_waddr = {r_bank, r_idx[cmh_pkg::ADDR_W-1:0]};
                head_wdata = cmh_pkg::NO_ENTRY;
                n_idx      = r_idx + cmh_pkg::CNT_W'(1);
                if (r_idx == cmh_pkg::BUCKET_RESET - cmh_pkg::CNT_W'(1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op     = cmh_pkg::t_op'(i_operation);
                    n_key    = i_key;
                    n_val    = i_value;
                    n_nb     = i_new_bucket_count;
                    n_found  = 1'b0;
                    n_rdval  = '0;
                    n_status = cmh_pkg::ST_OK;
                    if (cmh_pkg::t_op'(i_operation) == cmh_pkg::OP_RESIZE) begin
                        if (i_new_bucket_count == '0 ||
                            i_new_bucket_count > cmh_pkg::BUCKET_MAX) begin
                            n_status = cmh_pkg::ST_BAD;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_RS_CLR;
                        end
                    end else begin
                        mod_req.start = 1'b1;
                        n_state       = S_MOD;
                    end
                end
            end
            S_MOD: begin
                head_raddr = {r_bank, mod_rsp.rem};
                if (mod_rsp.done) begin
                    n_bkt   = mod_rsp.rem;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_bhead = hd;
                n_cur   = hd;
                n_prev  = cmh_pkg::NO_ENTRY;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_cur[cmh_pkg::IDX_W-1]) begin
                    // key absent
                    if (r_op == cmh_pkg::OP_PUT) begin
                        if (r_free[cmh_pkg::IDX_W-1]) begin
                            n_status = cmh_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            ent_raddr = r_free[cmh_pkg::ADDR_W-1:0];
                            n_state   = S_FREE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (key_rdata == r_key) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                    unique case (r_op)
                        cmh_pkg::OP_PUT: begin
                            val_we = 1'b1;
                        end
                        cmh_pkg::OP_GET: begin
                            n_rdval = val_rdata;
                        end
                        cmh_pkg::OP_REMOVE: begin
                            // unlink from the chain
                            if (!r_prev[cmh_pkg::IDX_W-1]) begin
                                link_we    = 1'b1;
                                link_waddr = r_prev[cmh_pkg::ADDR_W-1:0];
                                link_wdata = lnk;
                            end else begin
                                head_we    = 1'b1;
                                head_wdata = lnk;
                            end
                            n_state = S_REM2;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    n_prev  = r_cur;
                    n_cur   = lnk;
                    n_state = S_WALK;
                end
            end
            S_REM2: begin
                // push the removed entry onto the free list
                link_we = 1'b1;
                n_free  = r_cur;
                if (r_count != '0) begin
                    n_count = r_count - cmh_pkg::CNT_W'(1);
                end
                n_state = S_DONE;
            end
            S_FREE: begin
                // pop the free list and place the new entry at the chain head
                ent_waddr  = r_free[cmh_pkg::ADDR_W-1:0];
                link_waddr = r_free[cmh_pkg::ADDR_W-1:0];
                link_wdata = r_bhead;
                key_we     = 1'b1;
                val_we     = 1'b1;
                link_we    = 1'b1;
                head_we    = 1'b1;
                head_wdata = r_free;
                n_free     = lnk;
                n_count    = r_count + cmh_pkg::CNT_W'(1);
                n_state    = S_DONE;
            end
            S_RS_CLR: begin
                // empty the new buckets in the scratch bank
                head_we    = 1'b1;
                head_waddr = {~r_bank, r_idx[cmh_pkg::ADDR_W-1:0]};
                head_wdata = cmh_pkg::NO_ENTRY;
                n_idx      = r_idx + cmh_pkg::CNT_W'(1);
                if (r_idx == r_nb - cmh_pkg::CNT_W'(1)) begin
                    n_idx   = '0;
                    n_state = S_RS_HEAD;
                end
            end
            S_RS_HEAD: begin
                if (r_idx < r_nbuck) begin
                    head_raddr = {r_bank, r_idx[cmh_pkg::ADDR_W-1:0]};
                    n_state    = S_RS_HEADW;
                end else begin
                    n_bank  = ~r_bank;
                    n_nbuck = r_nb;
                    n_state = S_DONE;
                end
            end
            S_RS_HEADW: begin
                n_cur   = hd;
                n_state = S_RS_ENT;
            end
            S_RS_ENT: begin
                if (r_cur[cmh_pkg::IDX_W-1]) begin
                    n_idx   = r_idx + cmh_pkg::CNT_W'(1);
                    n_state = S_RS_HEAD;
                end else begin
                    n_state = S_RS_KEY;
                end
            end
            S_RS_KEY: begin
                n_next           = lnk;
                mod_req.start    = 1'b1;
                mod_req.dividend = {{(cmh_pkg::DVD_W - cmh_pkg::KEY_W){key_rdata[31]}},
                                    key_rdata};
                mod_req.divisor  = r_nb;
                n_state          = S_RS_MOD;
            end
            S_RS_MOD: begin
                head_raddr = {~r_bank, mod_rsp.rem};
                if (mod_rsp.done) begin
                    n_bkt   = mod_rsp.rem;
                    n_state = S_RS_SCR;
                end
            end
            S_RS_SCR: begin
                // push onto the new bucket in the scratch bank
                link_we    = 1'b1;
                link_wdata = hd;
                head_we    = 1'b1;
                head_waddr = {~r_bank, r_bkt};
                n_cur      = r_next;
                n_state    = S_RS_ENT;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_free  <= '0;
            r_count <= '0;
            r_nbuck <= cmh_pkg::BUCKET_RESET;
            r_bank  <= 1'b0;
            r_idx   <= '0;
            r_lv    <= '0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_count <= n_count;
            r_nbuck <= n_nbuck;
            r_bank  <= n_bank;
            r_idx   <= n_idx;
            if (link_we) begin
                r_lv[link_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_nb     <= n_nb;
        r_bkt    <= n_bkt;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_bhead  <= n_bhead;
        r_next   <= n_next;
        r_found  <= n_found;
        r_rdval  <= n_rdval;
        r_status <= n_status;
        r_lq_v   <= r_lv[ent_raddr];
        r_lq_a   <= ent_raddr;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_found       = r_found;
    assign o_read_value  = r_rdval;
    assign o_status      = r_status;
    assign o_entry_count = r_count;

    `CMH_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `CMH_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy)
    `CMH_ASSERT_SAME(a_full_no_hit, i_clk, i_rst_n,
        o_valid && o_status == cmh_pkg::ST_FULL, !o_found && r_free == cmh_pkg::NO_ENTRY)
    `CMH_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1,
        o_entry_count <= cmh_pkg::CNT_W'(cmh_pkg::MAX_ENTRIES))

endmodule

>>> src/cmh_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module cmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cmh_mod.sv
// shared bit-serial modulo unit: widened key modulo a bucket count
// depends on cmh_pkg
module cmh_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cmh_pkg::t_mod_req i_req,
    output cmh_pkg::t_mod_rsp o_rsp
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [5:0]                  r_cnt, n_cnt;
    logic [cmh_pkg::DVD_W-1:0]   r_dvd, n_dvd;
    logic [cmh_pkg::CNT_W-1:0]   r_dsr, n_dsr;
    logic [cmh_pkg::CNT_W-1:0]   r_rem, n_rem;
    logic [cmh_pkg::CNT_W:0]     trial;

    // one restoring step per cycle, msb of the dividend first
    always_comb begin
        trial  = {r_rem, r_dvd[cmh_pkg::DVD_W-1]};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '1;
            n_dvd  = i_req.dividend;
            n_dsr  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[cmh_pkg::DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = cmh_pkg::CNT_W'(trial - {1'b0, r_dsr});
            end else begin
                n_rem = trial[cmh_pkg::CNT_W-1:0];
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[cmh_pkg::ADDR_W-1:0];

endmodule
